@@ design/bldm_pkg.sv @@
// ----------------------------------------------------------------------------
// bldm_pkg
// Types, register indexes, reset values and the level to percent map shared
// by the battery level debounce monitor.
// ----------------------------------------------------------------------------
package bldm_pkg;

   localparam int SAMPLE_WIDTH     = 10;
   localparam int OFFSET_WIDTH     = 8;
   localparam int LEVEL_WIDTH      = 3;
   localparam int PERCENT_WIDTH    = 7;
   localparam int NUM_THRESHOLDS   = 5;
   localparam int CSR_INDEX_WIDTH  = 3;
   localparam int CSR_DATA_WIDTH   = 10;

   localparam int DEBOUNCE_COUNT_DEFAULT = 10;

   typedef logic [LEVEL_WIDTH-1:0] level_type;

   localparam level_type LEVEL_CRITICAL = 3'd0;
   localparam level_type LEVEL_WARNING  = 3'd1;
   localparam level_type LEVEL_QUARTER  = 3'd2;
   localparam level_type LEVEL_HALF     = 3'd3;
   localparam level_type LEVEL_HIGH     = 3'd4;
   localparam level_type LEVEL_FULL     = 3'd5;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_CRITICAL    = 3'd0,
      CSR_WARNING     = 3'd1,
      CSR_QUARTER     = 3'd2,
      CSR_HALF        = 3'd3,
      CSR_FULL        = 3'd4,
      CSR_LOAD_OFFSET = 3'd5
   } csr_index_type;

   localparam logic [NUM_THRESHOLDS-1:0][SAMPLE_WIDTH-1:0] THRESHOLD_RESET =
      {10'd319, 10'd296, 10'd277, 10'd269, 10'd265};
   localparam logic [OFFSET_WIDTH-1:0] LOAD_OFFSET_RESET = 8'd10;

   typedef struct packed {
      logic [SAMPLE_WIDTH-1:0] adc_sample;
      logic                    control_enabled;
      logic                    motor_running;
      logic                    charging;
   } req_payload_type;

   typedef struct packed {
      level_type                stable_level;
      logic [PERCENT_WIDTH-1:0] percent;
      logic                     level_changed;
      logic                     charging_changed;
   } rsp_payload_type;

   typedef struct packed {
      logic [NUM_THRESHOLDS-1:0][SAMPLE_WIDTH-1:0] threshold;
      logic [OFFSET_WIDTH-1:0]                     load_offset;
   } cfg_type;

   function automatic logic [PERCENT_WIDTH-1:0] bldm_percent(input level_type level);
      logic [PERCENT_WIDTH-1:0] pct;
      case (level)
         LEVEL_QUARTER: begin
            pct = 7'd25;
         end
         LEVEL_HALF: begin
            pct = 7'd50;
         end
         LEVEL_HIGH: begin
            pct = 7'd75;
         end
         LEVEL_FULL: begin
            pct = 7'd100;
         end
         default: begin
            pct = 7'd0;
         end
      endcase
      return pct;
   endfunction

endpackage

@@ design/bldm_csr.sv @@
// ----------------------------------------------------------------------------
// bldm_csr
// Threshold and load offset registers, written through a plain write port.
// ----------------------------------------------------------------------------
module bldm_csr
   import bldm_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_write_enable,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_write_data,
   output cfg_type                    cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_CRITICAL: begin
               cfg_in.threshold[0] = csr_write_data[SAMPLE_WIDTH-1:0];
            end
            CSR_WARNING: begin
               cfg_in.threshold[1] = csr_write_data[SAMPLE_WIDTH-1:0];
            end
            CSR_QUARTER: begin
               cfg_in.threshold[2] = csr_write_data[SAMPLE_WIDTH-1:0];
            end
            CSR_HALF: begin
               cfg_in.threshold[3] = csr_write_data[SAMPLE_WIDTH-1:0];
            end
            CSR_FULL: begin
               cfg_in.threshold[4] = csr_write_data[SAMPLE_WIDTH-1:0];
            end
            CSR_LOAD_OFFSET: begin
               cfg_in.load_offset = csr_write_data[OFFSET_WIDTH-1:0];
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.threshold   <= THRESHOLD_RESET;
         cfg_ff.load_offset <= LOAD_OFFSET_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

@@ design/bldm_grade.sv @@
// ----------------------------------------------------------------------------
// bldm_grade
// Lowers the thresholds under load and grades the sample into a level.
// ----------------------------------------------------------------------------
module bldm_grade
   import bldm_pkg::*;
(
   input  cfg_type                 cfg,
   input  logic [SAMPLE_WIDTH-1:0] adc_sample,
   input  logic                    loaded,
   output level_type               level
);

   logic [NUM_THRESHOLDS-1:0][SAMPLE_WIDTH:0]   diff;
   logic [NUM_THRESHOLDS-1:0][SAMPLE_WIDTH-1:0] lowered;
   logic [NUM_THRESHOLDS-1:0]                   below;

   always_comb begin
      for (int i = 0; i < NUM_THRESHOLDS; i++) begin
         diff[i] = {1'b0, cfg.threshold[i]}
                 - {{(SAMPLE_WIDTH + 1 - OFFSET_WIDTH){1'b0}}, cfg.load_offset};
         if (!loaded) begin
            lowered[i] = cfg.threshold[i];
         end else if (diff[i][SAMPLE_WIDTH]) begin
            lowered[i] = '0;
         end else begin
            lowered[i] = diff[i][SAMPLE_WIDTH-1:0];
         end
         below[i] = adc_sample < lowered[i];
      end
   end

   always_comb begin
      level = LEVEL_FULL;
      for (int i = NUM_THRESHOLDS - 1; i >= 0; i--) begin
         if (below[i]) begin
            level = LEVEL_WIDTH'(i);
         end
      end
   end

endmodule

@@ design/bldm_debounce.sv @@
// ----------------------------------------------------------------------------
// bldm_debounce
// Debounce state, charging edge detection and the result register.
// ----------------------------------------------------------------------------
module bldm_debounce
   import bldm_pkg::*;
#(
   parameter int DEBOUNCE_COUNT = DEBOUNCE_COUNT_DEFAULT
)
(
   input  logic            clock,
   input  logic            reset,
   input  logic            advance,
   input  level_type       level,
   input  logic            charging,
   input  logic            rsp_stall,
   output logic            rsp_valid,
   output rsp_payload_type rsp_word
);

   localparam int CountWidth = $clog2(DEBOUNCE_COUNT + 1);
   localparam logic [CountWidth:0] CountLimit = (CountWidth + 1)'(DEBOUNCE_COUNT);

   level_type             candidate_ff;
   level_type             candidate_in;
   level_type             stable_ff;
   level_type             stable_in;
   logic [CountWidth-1:0] count_ff;
   logic [CountWidth-1:0] count_in;
   logic                  last_charging_ff;
   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   rsp_payload_type       rsp_word_ff;
   rsp_payload_type       rsp_word_in;
   logic [CountWidth:0]   count_next;
   logic                  level_changed;

   always_comb begin
      candidate_in  = candidate_ff;
      stable_in     = stable_ff;
      count_in      = count_ff;
      level_changed = 1'b0;
      count_next    = {1'b0, count_ff} + (CountWidth + 1)'(1);
      if (level == candidate_ff) begin
         if (count_next >= CountLimit) begin
            if (stable_ff != level) begin
               stable_in     = level;
               level_changed = 1'b1;
            end
            count_in = CountLimit[CountWidth-1:0];
         end else begin
            count_in = count_next[CountWidth-1:0];
         end
      end else begin
         candidate_in = level;
         count_in     = '0;
      end
   end

   always_comb begin
      rsp_word_in.stable_level     = stable_in;
      rsp_word_in.percent          = bldm_percent(stable_in);
      rsp_word_in.level_changed    = level_changed;
      rsp_word_in.charging_changed = charging != last_charging_ff;
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         candidate_ff     <= LEVEL_FULL;
         stable_ff        <= LEVEL_FULL;
         count_ff         <= '0;
         last_charging_ff <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            candidate_ff     <= candidate_in;
            stable_ff        <= stable_in;
            count_ff         <= count_in;
            last_charging_ff <= charging;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_word_ff <= rsp_word_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

endmodule

@@ design/battery_level_debounce_monitor_core.sv @@
// ----------------------------------------------------------------------------
// battery_level_debounce_monitor_core
// Grades battery ADC samples into six levels and debounces the level.
//
// Each word on the req channel is one tick: a sample plus the enable, motor
// and charging bits. Each accepted word yields exactly one rsp word with the
// debounced level, its percentage and change pulses. A word is taken on a
// rising edge with valid high and stall low on its channel.
// A word is held in the input register and is graded and debounced on its
// way into the result register, which takes it unless a stalled result is
// still held there. One word per cycle is sustained while the receiver does
// not stall; the single grading and debounce stage sets that figure.
// When the receiver stalls, the result register holds its word and the
// input register may still take one more word before req_stall rises.
// Synchronous reset empties both registers, loads the threshold and load
// offset reset values and sets the debounced and candidate levels to full.
// Users must write csr port registers only while idle; the block does not check.
// ----------------------------------------------------------------------------
module battery_level_debounce_monitor_core
   import bldm_pkg::*;
#(
   parameter int DEBOUNCE_COUNT = DEBOUNCE_COUNT_DEFAULT
)
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  req_payload_type            req_word,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output rsp_payload_type            rsp_word,
   input  logic                       csr_write_enable,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_write_data
);

   cfg_type         cfg;
   logic            in_valid_ff;
   logic            in_valid_in;
   req_payload_type in_word_ff;
   logic            accept;
   logic            advance;
   level_type       level;

   assign advance   = in_valid_ff && (!rsp_valid || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (accept) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_word_ff <= req_word;
      end
   end

   bldm_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cfg              (cfg)
   );

   bldm_grade u_grade (
      .cfg        (cfg),
      .adc_sample (in_word_ff.adc_sample),
      .loaded     (in_word_ff.control_enabled && in_word_ff.motor_running),
      .level      (level)
   );

   bldm_debounce #(
      .DEBOUNCE_COUNT (DEBOUNCE_COUNT)
   ) u_debounce (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .level     (level),
      .charging  (in_word_ff.charging),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_word  (rsp_word)
   );

endmodule

@@ design/bldm_checker.sv @@
// ----------------------------------------------------------------------------
// bldm_checker
// Port level checks for the battery level debounce monitor.
// ----------------------------------------------------------------------------
module bldm_checker
   import bldm_pkg::*;
(
   input logic            clock,
   input logic            reset,
   input logic            req_valid,
   input logic            req_stall,
   input logic            rsp_valid,
   input logic            rsp_stall,
   input rsp_payload_type rsp_word
);

   // Reset empties the pipeline.
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // A stalled result stays in place unchanged.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_word))
      else $error("stalled result changed");

   a_level_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_word.stable_level <= LEVEL_FULL)
      else $error("stable level out of range");

   a_percent_match: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_word.percent == bldm_percent(rsp_word.stable_level))
      else $error("percent does not match level");

   // With the result side free, the input side never stalls.
   a_no_stall_when_free: assert property (@(posedge clock) disable iff (reset)
      req_valid && !rsp_valid |-> !req_stall)
      else $error("input stalled while result register empty");

endmodule

bind battery_level_debounce_monitor_core bldm_checker u_bldm_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_word  (rsp_word)
);

@@ tb/sv/bldm_report_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bldm_report_checker
// Watches the request, response and csr ports of the battery level debounce
// monitor. It keeps its own copy of the thresholds and the debounce state,
// predicts the report word for every accepted request word and compares each
// accepted response word with the oldest prediction, field by field.
// ----------------------------------------------------------------------------
module bldm_report_checker
   import bldm_pkg::*;
#(
   parameter int DEBOUNCE_TICKS = DEBOUNCE_COUNT_DEFAULT
)
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   input  logic                       req_stall,
   input  req_payload_type            req_word,
   input  logic                       rsp_valid,
   input  logic                       rsp_stall,
   input  rsp_payload_type            rsp_word,
   input  logic                       csr_write_enable,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_write_data,
   output int                         failures,
   output int                         outstanding
);

   cfg_type         settings;
   level_type       cand_level;
   level_type       held_level;
   int              match_run;
   logic            prev_charging;
   rsp_payload_type reports_due[$];

   function automatic level_type grade_sample(input logic [SAMPLE_WIDTH-1:0] sample,
                                              input logic loaded);
      logic [SAMPLE_WIDTH-1:0] limit;
      level_type               lvl;
      lvl = LEVEL_FULL;
      // Walk downward so that the matching threshold with the lowest index wins.
      for (int i = NUM_THRESHOLDS - 1; i >= 0; i--) begin
         limit = settings.threshold[i];
         if (loaded) begin
            limit = (limit > settings.load_offset) ? limit - settings.load_offset : '0;
         end
         if (sample < limit) begin
            lvl = level_type'(i);
         end
      end
      return lvl;
   endfunction

   function automatic logic [PERCENT_WIDTH-1:0] level_percent(input level_type lvl);
      case (lvl)
         LEVEL_QUARTER: return 7'd25;
         LEVEL_HALF:    return 7'd50;
         LEVEL_HIGH:    return 7'd75;
         LEVEL_FULL:    return 7'd100;
         default:       return 7'd0;
      endcase
   endfunction

   function automatic rsp_payload_type tick_report(input req_payload_type w);
      rsp_payload_type r;
      level_type       lvl;
      int              run;
      r = '0;
      lvl = grade_sample(w.adc_sample, w.control_enabled & w.motor_running);
      if (lvl == cand_level) begin
         run = match_run + 1;
         if (run >= DEBOUNCE_TICKS) begin
            if (held_level != lvl) begin
               held_level = lvl;
               r.level_changed = 1'b1;
            end
            run = DEBOUNCE_TICKS;
         end
         match_run = run;
      end else begin
         cand_level = lvl;
         match_run = 0;
      end
      if (w.charging != prev_charging) begin
         prev_charging = w.charging;
         r.charging_changed = 1'b1;
      end
      r.stable_level = held_level;
      r.percent = level_percent(held_level);
      return r;
   endfunction

   task automatic compare_field(input string name, input int want, input int got);
      if (want != got) begin
         $display("%0t ns: %s expected %0d actual %0d", $time, name, want, got);
         failures++;
      end
   endtask

   always @(posedge clock) begin : watch
      rsp_payload_type want;
      if (reset) begin
         settings.threshold = THRESHOLD_RESET;
         settings.load_offset = LOAD_OFFSET_RESET;
         cand_level = LEVEL_FULL;
         held_level = LEVEL_FULL;
         match_run = 0;
         prev_charging = 1'b0;
         reports_due.delete();
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               CSR_CRITICAL, CSR_WARNING, CSR_QUARTER, CSR_HALF, CSR_FULL: begin
                  settings.threshold[csr_index] = csr_write_data;
               end
               CSR_LOAD_OFFSET: begin
                  settings.load_offset = csr_write_data[OFFSET_WIDTH-1:0];
               end
               default: begin
               end
            endcase
         end
         if (rsp_valid && !rsp_stall) begin
            if (reports_due.size() == 0) begin
               $display("%0t ns: unexpected word, expected none, actual level %0d percent %0d",
                        $time, rsp_word.stable_level, rsp_word.percent);
               failures++;
            end else begin
               want = reports_due.pop_front();
               compare_field("stable_level", want.stable_level, rsp_word.stable_level);
               compare_field("percent", want.percent, rsp_word.percent);
               compare_field("level_changed", want.level_changed, rsp_word.level_changed);
               compare_field("charging_changed", want.charging_changed,
                             rsp_word.charging_changed);
            end
         end
         if (req_valid && !req_stall) begin
            reports_due.push_back(tick_report(req_word));
         end
      end
      outstanding = reports_due.size();
   end

endmodule

@@ tb/sv/tb_battery_level_debounce_monitor_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_battery_level_debounce_monitor_core
// Drives directed and random tick words into the battery level debounce
// monitor under several threshold settings, with random gaps on the request
// side and random stalls on the response side, and reports the verdict that
// the report checker reaches.
// ----------------------------------------------------------------------------
module tb_battery_level_debounce_monitor_core;
   import bldm_pkg::*;

   localparam int DEBOUNCE       = DEBOUNCE_COUNT_DEFAULT;
   localparam int RESET_CYCLES   = 11;
   localparam int DRAIN_CYCLES   = 4;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int PHASES         = 8;
   localparam int PHASE_TICKS    = 60;
   localparam int SAMPLE_MAX     = (1 << SAMPLE_WIDTH) - 1;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_UNUSED_LOW  =
      CSR_INDEX_WIDTH'(CSR_LOAD_OFFSET + 1);
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_UNUSED_HIGH = '1;

   typedef enum int {
      SETTING_EXTREME,
      SETTING_ASCENDING,
      SETTING_SCATTERED,
      SETTING_DEFAULT
   } setting_style_type;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_stall;
   req_payload_type            req_word = '0;
   logic                       rsp_valid;
   logic                       rsp_stall = 1'b0;
   rsp_payload_type            rsp_word;
   logic                       csr_write_enable = 1'b0;
   logic [CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [CSR_DATA_WIDTH-1:0]  csr_write_data = '0;

   int   fail_count;
   int   outstanding;
   int   quiet_cycles = 0;
   logic steady_flow = 1'b0;
   int   thr_next [NUM_THRESHOLDS];
   int   thr_now [NUM_THRESHOLDS];
   int   offset_raw;
   int   offset_now;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   battery_level_debounce_monitor_core #(
      .DEBOUNCE_COUNT(DEBOUNCE)
   ) dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_word         (req_word),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_word         (rsp_word),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   bldm_report_checker #(
      .DEBOUNCE_TICKS(DEBOUNCE)
   ) checker_i (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_word         (req_word),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_word         (rsp_word),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .failures         (fail_count),
      .outstanding      (outstanding)
   );

   function automatic int idle_length();
      int r;
      r = $urandom_range(0, 99);
      if (steady_flow || r < 55) begin
         return 0;
      end else if (r < 90) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(8, 40);
   endfunction

   function automatic int clamp_sample(input int v);
      if (v < 0) begin
         return 0;
      end else if (v > SAMPLE_MAX) begin
         return SAMPLE_MAX;
      end
      return v;
   endfunction

   function automatic req_payload_type tick_word(input int sample, input logic ce,
                                                 input logic mr, input logic chg);
      req_payload_type w;
      w.adc_sample = SAMPLE_WIDTH'(sample);
      w.control_enabled = ce;
      w.motor_running = mr;
      w.charging = chg;
      return w;
   endfunction

   // Picks a sample close to one of the current thresholds, or anywhere.
   function automatic int run_base(input logic loaded);
      int k;
      int v;
      int j;
      k = $urandom_range(0, NUM_THRESHOLDS);
      if (k == NUM_THRESHOLDS) begin
         return $urandom_range(0, SAMPLE_MAX);
      end
      v = thr_now[k];
      if (loaded) begin
         v = v - offset_now;
      end
      j = $urandom_range(0, 6);
      return clamp_sample(v + j - 3);
   endfunction

   task automatic send_tick(input req_payload_type w);
      int gap;
      gap = idle_length();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_word <= w;
      do begin
         @(posedge clock);
      end while (req_stall);
      @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_WIDTH-1:0] index, input int data);
      csr_write_enable <= 1'b1;
      csr_index <= index;
      csr_write_data <= CSR_DATA_WIDTH'(data);
      @(negedge clock);
   endtask

   task automatic load_settings();
      for (int k = 0; k < NUM_THRESHOLDS; k++) begin
         write_reg(csr_index_type'(k), thr_next[k]);
         thr_now[k] = thr_next[k] & SAMPLE_MAX;
      end
      write_reg(CSR_LOAD_OFFSET, offset_raw);
      offset_now = offset_raw & ((1 << OFFSET_WIDTH) - 1);
      csr_write_enable <= 1'b0;
      @(negedge clock);
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      @(negedge clock);
      while (outstanding != 0) begin
         @(negedge clock);
      end
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   initial begin : rsp_pacing
      int hold;
      forever begin
         hold = idle_length();
         @(negedge clock);
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(negedge clock);
         end
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("battery_level_debounce_monitor_core regression: fail");
         $finish;
      end
   end

   initial begin : stimulus
      int                sent;
      int                run_len;
      int                base;
      int                sample;
      int                v;
      logic              ce;
      logic              mr;
      logic              chg;
      setting_style_type style;

      for (int k = 0; k < NUM_THRESHOLDS; k++) begin
         thr_now[k] = THRESHOLD_RESET[k];
      end
      offset_now = LOAD_OFFSET_RESET;
      repeat (RESET_CYCLES) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Reset thresholds: charging on the first tick, a full debounce to
      // critical with the counter held at its limit, and the load cases.
      send_tick(tick_word(SAMPLE_MAX, 1'b0, 1'b0, 1'b1));
      repeat (DEBOUNCE + 2) send_tick(tick_word(0, 1'b0, 1'b0, 1'b1));
      send_tick(tick_word(260, 1'b1, 1'b1, 1'b0));
      send_tick(tick_word(260, 1'b1, 1'b0, 1'b0));
      send_tick(tick_word(260, 1'b0, 1'b1, 1'b0));
      send_tick(tick_word(10'h155, 1'b1, 1'b1, 1'b1));
      send_tick(tick_word(10'h2AA, 1'b0, 1'b0, 1'b0));
      send_tick(tick_word(SAMPLE_MAX, 1'b1, 1'b1, 1'b1));
      settle();

      // Thresholds out of order, an offset above two of the thresholds written with
      // its upper bits set, and writes to the unused indexes.
      thr_next[CSR_CRITICAL] = 500;
      thr_next[CSR_WARNING] = 100;
      thr_next[CSR_QUARTER] = SAMPLE_MAX;
      thr_next[CSR_HALF] = 0;
      thr_next[CSR_FULL] = 700;
      offset_raw = 10'h3FF;
      write_reg(CSR_UNUSED_LOW, 10'h3FF);
      write_reg(CSR_UNUSED_HIGH, 0);
      load_settings();
      send_tick(tick_word(499, 1'b0, 1'b0, 1'b0));
      send_tick(tick_word(499, 1'b1, 1'b1, 1'b0));
      send_tick(tick_word(600, 1'b0, 1'b0, 1'b0));
      send_tick(tick_word(SAMPLE_MAX, 1'b0, 1'b0, 1'b0));
      send_tick(tick_word(0, 1'b1, 1'b1, 1'b1));
      send_tick(tick_word(0, 1'b0, 1'b0, 1'b0));
      chg = 1'b0;

      for (int phase = 0; phase < PHASES; phase++) begin
         settle();
         steady_flow = (phase == PHASES / 2);
         if (phase == 0) begin
            for (int k = 0; k < NUM_THRESHOLDS; k++) thr_next[k] = SAMPLE_MAX;
            offset_raw = 0;
         end else if (phase == 1) begin
            for (int k = 0; k < NUM_THRESHOLDS; k++) thr_next[k] = 0;
            offset_raw = 255;
         end else begin
            style = setting_style_type'($urandom_range(0, 3));
            offset_raw = $urandom_range(0, SAMPLE_MAX);
            v = $urandom_range(0, 700);
            for (int k = 0; k < NUM_THRESHOLDS; k++) begin
               case (style)
                  SETTING_EXTREME: begin
                     thr_next[k] = $urandom_range(0, 1) ? SAMPLE_MAX : 0;
                  end
                  SETTING_ASCENDING: begin
                     thr_next[k] = v;
                     v = v + $urandom_range(0, 70);
                  end
                  SETTING_SCATTERED: begin
                     thr_next[k] = $urandom_range(0, SAMPLE_MAX);
                  end
                  default: begin
                     thr_next[k] = THRESHOLD_RESET[k];
                  end
               endcase
            end
            if (style == SETTING_EXTREME) begin
               offset_raw = ($urandom_range(0, 3) << OFFSET_WIDTH)
                            | ($urandom_range(0, 1) ? 255 : 0);
            end
         end
         load_settings();

         sent = 0;
         while (sent < PHASE_TICKS) begin
            if ($urandom_range(0, 9) < 8) begin
               // A run near one level, at times long enough to pass the debounce.
               run_len = $urandom_range(1, 24);
               ce = 1'($urandom_range(0, 1));
               mr = 1'($urandom_range(0, 1));
               base = run_base(ce & mr);
               for (int n = 0; n < run_len && sent < PHASE_TICKS; n++) begin
                  sample = base;
                  if ($urandom_range(0, 4) == 0) begin
                     sample = clamp_sample(base + $urandom_range(0, 6) - 3);
                  end
                  if ($urandom_range(0, 19) < 3) ce = ~ce;
                  if ($urandom_range(0, 19) < 3) mr = ~mr;
                  if ($urandom_range(0, 9) == 0) chg = ~chg;
                  send_tick(tick_word(sample, ce, mr, chg));
                  sent++;
               end
            end else begin
               send_tick(tick_word($urandom_range(0, SAMPLE_MAX), 1'($urandom_range(0, 1)),
                                   1'($urandom_range(0, 1)), 1'($urandom_range(0, 1))));
               sent++;
            end
         end
      end
      steady_flow = 1'b0;
      settle();

      if (fail_count == 0 && outstanding == 0) begin
         $display("battery_level_debounce_monitor_core regression: pass");
      end else begin
         $display("battery_level_debounce_monitor_core regression: fail");
      end
      $finish;
   end

endmodule
